@@ rtl/level_set_fire_front_cell_update_assert.svh @@
// assertion macros for the fire front cell update checker
`ifndef LEVEL_SET_FIRE_FRONT_CELL_UPDATE_ASSERT_SVH
`define LEVEL_SET_FIRE_FRONT_CELL_UPDATE_ASSERT_SVH

// implication checked at every clock edge outside reset
`define LSFCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fire front cell update: implication failed");

// condition that holds at every clock edge outside reset
`define LSFCU_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fire front cell update: invariant failed");

`endif

@@ rtl/lsfcu_pkg.sv @@
// types, constants and register codes shared by the fire front cell update block
`default_nettype none
package lsfcu_pkg;

	typedef enum logic [1:0] {
		CFG_INV_X = 2'd0,
		CFG_INV_Y = 2'd1,
		CFG_DT    = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BS_UNBURNED = 2'd0,
		BS_PREHEAT  = 2'd1,
		BS_BURNING  = 2'd2,
		BS_BURNED   = 2'd3
	} burn_t;

	typedef struct packed {
		logic signed [23:0] level_center;
		logic signed [23:0] level_west;
		logic signed [23:0] level_east;
		logic signed [23:0] level_south;
		logic signed [23:0] level_north;
		logic signed [15:0] spread_force;
		logic [1:0]         burn_state;
		logic [23:0]        burn_elapsed;
		logic [23:0]        residence_time;
	} item_t;

	typedef struct packed {
		logic signed [23:0] new_level;
		logic [1:0]         new_burn_state;
		logic [23:0]        new_burn_time;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
	} res_t;

	localparam logic [15:0] INV_X_RESET = 16'd4096;
	localparam logic [15:0] INV_Y_RESET = 16'd4096;
	localparam logic [15:0] DT_RESET    = 16'd256;

	// root widths of the gradient and normal square roots
	localparam int GRAD_RW = 30;
	localparam int NORM_RW = 31;
	localparam int QUO_W   = 15;

	localparam int LAT = 97;

	localparam logic signed [63:0] LEVEL_MAX     = 64'sd8388607;
	localparam logic signed [63:0] LEVEL_MIN     = -64'sd8388608;
	localparam logic signed [63:0] PREHEAT_LEVEL = 64'sd256;
	localparam logic signed [63:0] IGNITE_LEVEL  = 64'sd2;
	localparam logic [23:0]        TIME_MAX      = 24'hFFFFFF;

endpackage
`default_nettype wire

@@ rtl/level_set_fire_front_cell_update.sv @@
// top level: upwind level-set advance, front normal and burn state of one cell per beat
//
// channel   direction  handshake             payload
// item      in         start, busy           lsfcu_pkg::item_t
// result    out        strobe                lsfcu_pkg::res_t
// config    in         cfg_valid, cfg_ready  cfg_index, cfg_data
//
// one cell per clock; each result leaves from the stage 97 result register
// the path to the result runs through two chained square root pipelines (30 and 31 stages)
// and two chained levels of divider pipelines (15 stages each)
// busy stays low and cfg_ready high; nothing in the pipeline ever stalls
// reset clears the valid line and loads the register defaults
`default_nettype none
module level_set_fire_front_cell_update (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire lsfcu_pkg::item_t  item,
	output logic                   strobe,
	output lsfcu_pkg::res_t        result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import lsfcu_pkg::*;

	function automatic logic [28:0] abs29(logic signed [28:0] v);
		return v[28] ? 29'(-v) : 29'(v);
	endfunction

	function automatic logic [16:0] abs18(logic signed [17:0] v);
		logic signed [17:0] a;
		a = v[17] ? -v : v;
		return a[16:0];
	endfunction

	logic [15:0] inv_x_q, inv_y_q, dt_q;
	logic        vld_s [1:LAT];
	logic        acc;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc       = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q <= INV_X_RESET;
			inv_y_q <= INV_Y_RESET;
			dt_q    <= DT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INV_X: inv_x_q <= cfg_data;
				CFG_INV_Y: inv_y_q <= cfg_data;
				CFG_DT:    dt_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[1] <= acc;
			for (int i = 2; i <= LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// stage 1: scaled differences
	item_t              item_s1;
	logic signed [41:0] pmx_s1, ppx_s1, pmy_s1, ppy_s1;
	logic signed [24:0] dif_mx, dif_px, dif_my, dif_py;

	assign dif_mx = 25'(item.level_center) - 25'(item.level_west);
	assign dif_px = 25'(item.level_east)   - 25'(item.level_center);
	assign dif_my = 25'(item.level_center) - 25'(item.level_south);
	assign dif_py = 25'(item.level_north)  - 25'(item.level_center);

	always_ff @(posedge clk) begin
		item_s1 <= item;
		pmx_s1  <= dif_mx * $signed({1'b0, inv_x_q});
		ppx_s1  <= dif_px * $signed({1'b0, inv_x_q});
		pmy_s1  <= dif_my * $signed({1'b0, inv_y_q});
		ppy_s1  <= dif_py * $signed({1'b0, inv_y_q});
	end

	// stage 2: gradients and their squares
	logic signed [28:0] dmx, dpx, dmy, dpy;
	logic signed [28:0] dmx_s2, dpx_s2, dmy_s2, dpy_s2;
	logic [56:0]        sq_mx_s2, sq_px_s2, sq_my_s2, sq_py_s2;

	assign dmx = pmx_s1[40:12];
	assign dpx = ppx_s1[40:12];
	assign dmy = pmy_s1[40:12];
	assign dpy = ppy_s1[40:12];

	always_ff @(posedge clk) begin
		dmx_s2   <= dmx;
		dpx_s2   <= dpx;
		dmy_s2   <= dmy;
		dpy_s2   <= dpy;
		sq_mx_s2 <= 57'(abs29(dmx) * abs29(dmx));
		sq_px_s2 <= 57'(abs29(dpx) * abs29(dpx));
		sq_my_s2 <= 57'(abs29(dmy) * abs29(dmy));
		sq_py_s2 <= 57'(abs29(dpy) * abs29(dpy));
	end

	// stage 3: radicands
	logic [2*GRAD_RW-1:0] rad_p_s3, rad_m_s3, rad_pp_s3, rad_mp_s3, rad_pm_s3, rad_mm_s3;

	always_ff @(posedge clk) begin
		rad_p_s3 <= (dmx_s2 > 0 ? 60'(sq_mx_s2) : 60'd0) + (dpx_s2 < 0 ? 60'(sq_px_s2) : 60'd0)
			+ (dmy_s2 > 0 ? 60'(sq_my_s2) : 60'd0) + (dpy_s2 < 0 ? 60'(sq_py_s2) : 60'd0);
		rad_m_s3 <= (dpx_s2 > 0 ? 60'(sq_px_s2) : 60'd0) + (dmx_s2 < 0 ? 60'(sq_mx_s2) : 60'd0)
			+ (dpy_s2 > 0 ? 60'(sq_py_s2) : 60'd0) + (dmy_s2 < 0 ? 60'(sq_my_s2) : 60'd0);
		rad_pp_s3 <= 60'(sq_px_s2) + 60'(sq_py_s2);
		rad_mp_s3 <= 60'(sq_mx_s2) + 60'(sq_py_s2);
		rad_pm_s3 <= 60'(sq_px_s2) + 60'(sq_my_s2);
		rad_mm_s3 <= 60'(sq_mx_s2) + 60'(sq_my_s2);
	end

	// stages 4 to 33: gradient roots
	logic [GRAD_RW-1:0] del_p, del_m, r_pp, r_mp, r_pm, r_mm;

	lsfcu_isqrt #(.MW(GRAD_RW)) u_sq_p  (.clk, .rad(rad_p_s3),  .root(del_p));
	lsfcu_isqrt #(.MW(GRAD_RW)) u_sq_m  (.clk, .rad(rad_m_s3),  .root(del_m));
	lsfcu_isqrt #(.MW(GRAD_RW)) u_sq_pp (.clk, .rad(rad_pp_s3), .root(r_pp));
	lsfcu_isqrt #(.MW(GRAD_RW)) u_sq_mp (.clk, .rad(rad_mp_s3), .root(r_mp));
	lsfcu_isqrt #(.MW(GRAD_RW)) u_sq_pm (.clk, .rad(rad_pm_s3), .root(r_pm));
	lsfcu_isqrt #(.MW(GRAD_RW)) u_sq_mm (.clk, .rad(rad_mm_s3), .root(r_mm));

	logic [115:0]       grads_d;
	logic signed [28:0] gmx, gpx, gmy, gpy;

	lsfcu_delay #(.W(116), .N(GRAD_RW + 1)) u_dly_grad (
		.clk,
		.d({dmx_s2, dpx_s2, dmy_s2, dpy_s2}),
		.q(grads_d)
	);
	assign {gmx, gpx, gmy, gpy} = grads_d;

	item_t item_d;

	lsfcu_delay #(.W($bits(item_t)), .N(GRAD_RW + 2)) u_dly_item (
		.clk,
		.d(item_s1),
		.q(item_d)
	);

	// unit normal terms, stages 34 to 48
	localparam int UNW = GRAD_RW + QUO_W;
	logic signed [QUO_W:0] ux_pp, ux_mp, ux_pm, ux_mm, uy_pp, uy_mp, uy_pm, uy_mm;

	lsfcu_div #(.DW(GRAD_RW), .QW(QUO_W)) u_div_x_pp (.clk,
		.num(UNW'({abs29(gpx), 14'd0})), .den(r_pp), .neg(gpx[28]), .quo(ux_pp));
	lsfcu_div #(.DW(GRAD_RW), .QW(QUO_W)) u_div_x_mp (.clk,
		.num(UNW'({abs29(gmx), 14'd0})), .den(r_mp), .neg(gmx[28]), .quo(ux_mp));
	lsfcu_div #(.DW(GRAD_RW), .QW(QUO_W)) u_div_x_pm (.clk,
		.num(UNW'({abs29(gpx), 14'd0})), .den(r_pm), .neg(gpx[28]), .quo(ux_pm));
	lsfcu_div #(.DW(GRAD_RW), .QW(QUO_W)) u_div_x_mm (.clk,
		.num(UNW'({abs29(gmx), 14'd0})), .den(r_mm), .neg(gmx[28]), .quo(ux_mm));
	lsfcu_div #(.DW(GRAD_RW), .QW(QUO_W)) u_div_y_pp (.clk,
		.num(UNW'({abs29(gpy), 14'd0})), .den(r_pp), .neg(gpy[28]), .quo(uy_pp));
	lsfcu_div #(.DW(GRAD_RW), .QW(QUO_W)) u_div_y_mp (.clk,
		.num(UNW'({abs29(gpy), 14'd0})), .den(r_mp), .neg(gpy[28]), .quo(uy_mp));
	lsfcu_div #(.DW(GRAD_RW), .QW(QUO_W)) u_div_y_pm (.clk,
		.num(UNW'({abs29(gmy), 14'd0})), .den(r_pm), .neg(gmy[28]), .quo(uy_pm));
	lsfcu_div #(.DW(GRAD_RW), .QW(QUO_W)) u_div_y_mm (.clk,
		.num(UNW'({abs29(gmy), 14'd0})), .den(r_mm), .neg(gmy[28]), .quo(uy_mm));

	// level path, stages 34 to 36
	logic signed [46:0] rate_s34;
	logic signed [63:0] chg_s35;
	item_t              item_s34, item_s35;

	always_ff @(posedge clk) begin
		item_s34 <= item_d;
		item_s35 <= item_s34;
		if (item_d.spread_force > 0) begin
			rate_s34 <= item_d.spread_force * $signed({1'b0, del_p});
		end else begin
			rate_s34 <= item_d.spread_force * $signed({1'b0, del_m});
		end
		chg_s35 <= 64'(rate_s34) * 64'($signed({1'b0, dt_q}));
	end

	logic signed [63:0] chg, lvl;
	logic [24:0]        bt_sum;
	logic [23:0]        bt;
	logic [1:0]         st, ns;
	logic               cool;
	res_t               lvl_res, lvl_res_s36, lvl_res_d;

	always_comb begin
		chg  = (chg_s35 + 64'sd32768) >>> 16;
		lvl  = 64'(item_s35.level_center) - chg;
		if (lvl > LEVEL_MAX) begin
			lvl = LEVEL_MAX;
		end
		if (lvl < LEVEL_MIN) begin
			lvl = LEVEL_MIN;
		end
		st   = item_s35.burn_state;
		cool = (st == BS_UNBURNED) || (st == BS_PREHEAT);
		ns   = st;
		if (lvl <= PREHEAT_LEVEL && cool) begin
			ns = BS_PREHEAT;
		end
		if (lvl <= IGNITE_LEVEL && cool) begin
			ns = BS_BURNING;
		end
		bt_sum = {1'b0, item_s35.burn_elapsed} + 25'(dt_q);
		bt     = item_s35.burn_elapsed;
		if (st == BS_BURNING) begin
			bt = bt_sum[24] ? TIME_MAX : bt_sum[23:0];
		end
		if (bt >= item_s35.residence_time) begin
			ns = BS_BURNED;
		end
		lvl_res                = '0;
		lvl_res.new_level      = lvl[23:0];
		lvl_res.new_burn_state = ns;
		lvl_res.new_burn_time  = bt;
	end

	always_ff @(posedge clk) begin
		lvl_res_s36 <= lvl_res;
	end

	lsfcu_delay #(.W($bits(res_t)), .N(LAT - 37)) u_dly_lvl (
		.clk,
		.d(lvl_res_s36),
		.q(lvl_res_d)
	);

	// stages 49 and 50: summed normal and its squared length
	logic signed [17:0] nsx_s49, nsy_s49;
	logic [33:0]        sq_nx_s50, sq_ny_s50;

	always_ff @(posedge clk) begin
		nsx_s49   <= 18'(ux_pp) + 18'(ux_mp) + 18'(ux_pm) + 18'(ux_mm);
		nsy_s49   <= 18'(uy_pp) + 18'(uy_mp) + 18'(uy_pm) + 18'(uy_mm);
		sq_nx_s50 <= 34'(abs18(nsx_s49) * abs18(nsx_s49));
		sq_ny_s50 <= 34'(abs18(nsy_s49) * abs18(nsy_s49));
	end

	// stages 51 to 81: normal length
	logic [2*NORM_RW-1:0] rad_n;
	logic [NORM_RW-1:0]   mag;
	logic [33:0]          sq_n_sum;

	assign sq_n_sum = sq_nx_s50 + sq_ny_s50;
	assign rad_n    = {sq_n_sum, 28'd0};

	lsfcu_isqrt #(.MW(NORM_RW)) u_sq_n (.clk, .rad(rad_n), .root(mag));

	logic [35:0]        ns_d;
	logic signed [17:0] nsx_d, nsy_d;

	lsfcu_delay #(.W(36), .N(NORM_RW + 1)) u_dly_ns (
		.clk,
		.d({nsx_s49, nsy_s49}),
		.q(ns_d)
	);
	assign {nsx_d, nsy_d} = ns_d;

	// stages 82 to 96: normalization
	localparam int NNW = NORM_RW + QUO_W;
	logic signed [QUO_W:0] nx, ny;

	lsfcu_div #(.DW(NORM_RW), .QW(QUO_W)) u_div_nx (.clk,
		.num(NNW'({abs18(nsx_d), 28'd0})), .den(mag), .neg(nsx_d[17]), .quo(nx));
	lsfcu_div #(.DW(NORM_RW), .QW(QUO_W)) u_div_ny (.clk,
		.num(NNW'({abs18(nsy_d), 28'd0})), .den(mag), .neg(nsy_d[17]), .quo(ny));

	// stage 97: result register
	res_t res_s97;

	always_ff @(posedge clk) begin
		res_s97 <= {lvl_res_d.new_level, lvl_res_d.new_burn_state, lvl_res_d.new_burn_time,
			nx, ny};
	end

	assign result = res_s97;
	assign strobe = vld_s[LAT];
endmodule
`default_nettype wire

@@ rtl/lsfcu_isqrt.sv @@
// pipelined floor square root, one root bit per stage
`default_nettype none
module lsfcu_isqrt #(
	parameter int MW = 30
) (
	input  wire logic              clk,
	input  wire logic [2*MW-1:0]   rad,
	output logic      [MW-1:0]     root
);
	logic [MW+1:0] rem_s  [1:MW];
	logic [MW-1:0] root_s [1:MW];
	logic [2*MW-1:0] rad_s [1:MW];

	for (genvar k = 0; k < MW; k++) begin : g_stage
		logic [MW+1:0]   cur_rem;
		logic [MW-1:0]   cur_root;
		logic [2*MW-1:0] cur_rad;
		logic [MW+1:0]   pre;
		logic [MW+1:0]   trial;
		if (k == 0) begin : g_first
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_rad  = rad;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_rad  = rad_s[k];
		end
		assign pre   = {cur_rem[MW-1:0], cur_rad[2*MW-1 -: 2]};
		assign trial = {cur_root, 2'b01};
		always_ff @(posedge clk) begin
			rad_s[k+1] <= cur_rad << 2;
			if (pre >= trial) begin
				rem_s[k+1]  <= pre - trial;
				root_s[k+1] <= {cur_root[MW-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= pre;
				root_s[k+1] <= {cur_root[MW-2:0], 1'b0};
			end
		end
	end

	assign root = root_s[MW];
endmodule
`default_nettype wire

@@ rtl/lsfcu_div.sv @@
// pipelined restoring divider, one quotient bit per stage, signed result
`default_nettype none
module lsfcu_div #(
	parameter int DW = 30,
	parameter int QW = 15
) (
	input  wire logic                 clk,
	input  wire logic [DW+QW-1:0]     num,
	input  wire logic [DW-1:0]        den,
	input  wire logic                 neg,
	output logic signed [QW:0]        quo
);
	localparam int NW = DW + QW;

	logic [NW-1:0] rem_s [1:QW];
	logic [DW-1:0] den_s [1:QW];
	logic [QW-1:0] q_s   [1:QW];
	logic          neg_s [1:QW];
	logic signed [QW:0] mag;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW-1:0] cur_rem;
		logic [DW-1:0] cur_den;
		logic [QW-1:0] cur_q;
		logic          cur_neg;
		logic [NW-1:0] dsh;
		if (k == 0) begin : g_first
			assign cur_rem = num;
			assign cur_den = den;
			assign cur_q   = '0;
			assign cur_neg = neg;
		end else begin : g_next
			assign cur_rem = rem_s[k];
			assign cur_den = den_s[k];
			assign cur_q   = q_s[k];
			assign cur_neg = neg_s[k];
		end
		assign dsh = NW'(cur_den) << (QW - 1 - k);
		always_ff @(posedge clk) begin
			den_s[k+1] <= cur_den;
			neg_s[k+1] <= cur_neg;
			if (cur_rem >= dsh) begin
				rem_s[k+1] <= cur_rem - dsh;
				q_s[k+1]   <= {cur_q[QW-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= cur_rem;
				q_s[k+1]   <= {cur_q[QW-2:0], 1'b0};
			end
		end
	end

	assign mag = $signed({1'b0, q_s[QW]});

	// zero divisor gives zero
	always_comb begin
		if (den_s[QW] == '0) begin
			quo = '0;
		end else if (neg_s[QW]) begin
			quo = -mag;
		end else begin
			quo = mag;
		end
	end
endmodule
`default_nettype wire

@@ rtl/lsfcu_delay.sv @@
// fixed-length shift line for payload that waits on a longer path
`default_nettype none
module lsfcu_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);
	logic [W-1:0] sr [N];

	always_ff @(posedge clk) begin
		sr[0] <= d;
		for (int i = 1; i < N; i++) begin
			sr[i] <= sr[i-1];
		end
	end

	assign q = sr[N-1];
endmodule
`default_nettype wire

@@ rtl/lsfcu_checker.sv @@
// port checker for the fire front cell update block, bound to the top level
`default_nettype none
`include "level_set_fire_front_cell_update_assert.svh"
module lsfcu_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire lsfcu_pkg::item_t item,
	input wire logic             strobe,
	input wire lsfcu_pkg::res_t  result
);
	import lsfcu_pkg::*;

	localparam logic signed [15:0] NRM_ONE = 16'sd16384;

	logic was_burned;

	assign was_burned = (item.burn_state == BS_BURNED);

	`LSFCU_ASSERT_IMP(a_latency, strobe, $past(start && !busy, LAT))
	`LSFCU_ASSERT_ALWAYS(a_nx_range, !strobe || (result.normal_x <= NRM_ONE && result.normal_x >= -NRM_ONE))
	`LSFCU_ASSERT_ALWAYS(a_ny_range, !strobe || (result.normal_y <= NRM_ONE && result.normal_y >= -NRM_ONE))
	`LSFCU_ASSERT_IMP(a_burned_stays, strobe && $past(was_burned, LAT), result.new_burn_state == BS_BURNED)
	`LSFCU_ASSERT_IMP(a_time_grows, strobe, result.new_burn_time >= $past(item.burn_elapsed, LAT))
endmodule

bind level_set_fire_front_cell_update lsfcu_checker u_lsfcu_checker (.*);
`default_nettype wire
